FILE: hdl/continued_fraction_rational_approx_unit_assert.svh
// Assertion macros for the continued-fraction approximation unit.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef CONTINUED_FRACTION_RATIONAL_APPROX_UNIT_ASSERT_SVH
`define CONTINUED_FRACTION_RATIONAL_APPROX_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define CFRA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfra assertion failed");
// next-cycle implication
`define CFRA_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfra assertion failed");
`else
`define CFRA_ASSERT_IMP(name, ante, cons)
`define CFRA_ASSERT_NXT(name, ante, cons)
`endif

`endif

FILE: hdl/cfra_pkg.sv
// Shared constants and types for the continued-fraction approximation unit.
// No dependencies.
package cfra_pkg;

    localparam int VALUE_W       = 64;
    localparam int WHOLE_W       = 32;
    localparam int NUM_W         = 17;
    localparam int DEN_W         = 16;
    localparam int FRAC_BITS_DEF = 32;
    localparam int DVD_W         = 128;
    localparam int QUO_W         = 64;
    localparam int CNT_W         = 8;
    localparam int MAC_A_W       = 16;

    localparam logic [DEN_W-1:0] MAXDEN_RESET = 16'd1000;
    localparam logic [30:0]      RECIP_LIMIT  = 31'h7FFFFFFF;

    // divider start request
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nbits;
    } cfra_div_req_t;

    // shared unit status
    typedef struct packed {
        logic busy;
        logic done;
    } cfra_stat_t;

endpackage

FILE: hdl/cfra_in_if.sv
// Input request channel: valid/ready plus the fixed-point value.
// Depends on cfra_pkg.
interface cfra_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cfra_pkg::VALUE_W-1:0]  value_fixed;

    modport source (output valid, output value_fixed, input ready);
    modport sink   (input valid, input value_fixed, output ready);
endinterface

FILE: hdl/cfra_out_if.sv
// Result channel: valid/ready plus the mixed-number fields.
// Depends on cfra_pkg.
interface cfra_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [cfra_pkg::WHOLE_W-1:0] whole_part;
    logic signed [cfra_pkg::NUM_W-1:0]   numerator;
    logic [cfra_pkg::DEN_W-1:0]          denominator;

    modport source (output valid, output whole_part, output numerator,
                    output denominator, input ready);
    modport sink   (input valid, input whole_part, input numerator,
                    input denominator, output ready);
endinterface

FILE: hdl/continued_fraction_rational_approx_unit.sv
// Continued-fraction rational approximation: one signed fixed-point value
// in, one mixed number (whole part, numerator, denominator) out. Requests
// are handled one at a time; in_ch.ready is low while a request is worked
// on. Each convergent step costs one reciprocal division on the shared
// bit-serial divider plus two shift-add multiplies and control states; the
// final split of p/q costs another division on the same divider. Values are
// Q32.32 by default, and the denominator limit resets to 1000.
// A finished result waits in the output register while the next request
// is taken. Depends on cfra_pkg, cfra_in_if, cfra_out_if, cfra_div, cfra_mac.
`include "continued_fraction_rational_approx_unit_assert.svh"

module continued_fraction_rational_approx_unit #(
    parameter int FRAC_BITS = cfra_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [cfra_pkg::DEN_W-1:0] cfg_wr_data,
    cfra_in_if.sink                    in_ch,
    cfra_out_if.source                 out_ch
);
    import cfra_pkg::*;

    localparam int AI_W = VALUE_W - FRAC_BITS;
    localparam int CHK_W = 96;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHKF = 3'd1;
    localparam logic [2:0] ST_DIVR = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_MQ   = 3'd4;
    localparam logic [2:0] ST_MP   = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;
    localparam logic [2:0] ST_DIVF = 3'd7;

    localparam logic [CHK_W-1:0] ONE_FB = CHK_W'(1) << FRAC_BITS;

    logic [2:0]         state_reg, state_next;
    logic [DEN_W-1:0]   maxden_reg;
    logic [VALUE_W-1:0] x_reg, x_next;
    logic               neg_reg, neg_next;
    logic [VALUE_W-1:0] p0_reg, p0_next, p1_reg, p1_next;
    logic [DEN_W-1:0]   q0_reg, q0_next, q1_reg, q1_next, tq_reg, tq_next;
    logic               ov_reg, ov_next;
    logic [WHOLE_W-1:0] whole_reg, whole_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;

    logic [DEN_W-1:0]     lim;
    logic [FRAC_BITS-1:0] frac;
    logic [AI_W-1:0]      ai;
    logic [VALUE_W-1:0]   abs_in;
    logic                 recip_stop;
    logic [CHK_W-1:0]     frac_x_lim;
    logic [CHK_W-1:0]     frac_sh;

    cfra_div_req_t        div_req;
    logic [DVD_W-1:0]     div_dvd;
    logic [FRAC_BITS-1:0] div_dsr;
    cfra_stat_t           div_stat;
    logic [QUO_W-1:0]     div_quo;
    logic [FRAC_BITS-1:0] div_rem;

    logic                 mac_start;
    logic [VALUE_W-1:0]   mac_b, mac_c, mac_res;
    cfra_stat_t           mac_stat;

    logic [VALUE_W-1:0]   whole64;
    logic [VALUE_W-1:0]   sat64;
    logic                 out_free;

    cfra_div #(.DIV_W(FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    cfra_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .b     (mac_b),
        .a     (ai[MAC_A_W-1:0]),
        .c     (mac_c),
        .stat  (mac_stat),
        .res   (mac_res)
    );

    // operand views
    assign lim    = (maxden_reg == '0) ? DEN_W'(1) : maxden_reg;
    assign frac   = x_reg[FRAC_BITS-1:0];
    assign ai     = x_reg[VALUE_W-1:FRAC_BITS];
    assign abs_in = in_ch.value_fixed[VALUE_W-1] ? (VALUE_W'(0) - in_ch.value_fixed)
                                                 : in_ch.value_fixed;

    // reciprocal out of range: 2^FB/f > limit, or integer part too wide
    assign frac_x_lim = CHK_W'(frac) * CHK_W'(RECIP_LIMIT);
    assign frac_sh    = CHK_W'(frac) << AI_W;
    assign recip_stop = (frac_x_lim < ONE_FB) || (frac_sh <= ONE_FB);

    assign out_free = !ov_reg || out_ch.ready;

    // final split with sign and saturation
    assign whole64 = div_quo;
    always_comb
    begin
        if (neg_reg)
            sat64 = (whole64 > VALUE_W'(64'h8000_0000)) ? VALUE_W'(64'h8000_0000) : whole64;
        else
            sat64 = (whole64 > VALUE_W'(64'h7FFF_FFFF)) ? VALUE_W'(64'h7FFF_FFFF) : whole64;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        x_next        = x_reg;
        neg_next      = neg_reg;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        q0_next       = q0_reg;
        q1_next       = q1_reg;
        tq_next       = tq_reg;
        ov_next       = ov_reg && !out_ch.ready;
        whole_next    = whole_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        div_req.start = 1'b0;
        div_req.nbits = CNT_W'(2 * FRAC_BITS + 1);
        div_dvd       = DVD_W'(1) << (DVD_W - 1);
        div_dsr       = frac;
        mac_start     = 1'b0;
        mac_b         = VALUE_W'(q1_reg);
        mac_c         = VALUE_W'(q0_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    // first convergent: p = a0, q = 1
                    x_next     = abs_in;
                    neg_next   = in_ch.value_fixed[VALUE_W-1];
                    p1_next    = VALUE_W'(abs_in[VALUE_W-1:FRAC_BITS]);
                    p0_next    = VALUE_W'(1);
                    q1_next    = DEN_W'(1);
                    q0_next    = '0;
                    state_next = ST_CHKF;
                end
            end
            ST_CHKF:
            begin
                if (frac == '0 || recip_stop)
                    state_next = ST_FIN;
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIVR;
                end
            end
            ST_DIVR:
            begin
                if (div_stat.done)
                begin
                    x_next     = div_quo;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (ai > AI_W'(lim))
                    state_next = ST_FIN;
                else
                begin
                    mac_start  = 1'b1;
                    state_next = ST_MQ;
                end
            end
            ST_MQ:
            begin
                if (mac_stat.done)
                begin
                    if (mac_res > VALUE_W'(lim))
                        state_next = ST_FIN;
                    else
                    begin
                        tq_next    = mac_res[DEN_W-1:0];
                        mac_b      = p1_reg;
                        mac_c      = p0_reg;
                        mac_start  = 1'b1;
                        state_next = ST_MP;
                    end
                end
            end
            ST_MP:
            begin
                mac_b = p1_reg;
                mac_c = p0_reg;
                if (mac_stat.done)
                begin
                    p0_next    = p1_reg;
                    p1_next    = mac_res;
                    q0_next    = q1_reg;
                    q1_next    = tq_reg;
                    state_next = ST_CHKF;
                end
            end
            ST_FIN:
            begin
                div_req.start = 1'b1;
                div_req.nbits = CNT_W'(VALUE_W);
                div_dvd       = {p1_reg, {(DVD_W - VALUE_W){1'b0}}};
                div_dsr       = FRAC_BITS'(q1_reg);
                state_next    = ST_DIVF;
            end
            ST_DIVF:
            begin
                div_dsr = FRAC_BITS'(q1_reg);
                if (div_stat.done && out_free)
                begin
                    ov_next  = 1'b1;
                    den_next = q1_reg;
                    if (whole64 != '0)
                    begin
                        num_next   = NUM_W'(div_rem[DEN_W-1:0]);
                        whole_next = neg_reg ? (WHOLE_W'(0) - sat64[WHOLE_W-1:0])
                                             : sat64[WHOLE_W-1:0];
                    end
                    else
                    begin
                        whole_next = '0;
                        num_next   = neg_reg ? (NUM_W'(0) - p1_reg[NUM_W-1:0])
                                             : p1_reg[NUM_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ov_reg     <= 1'b0;
            maxden_reg <= MAXDEN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (cfg_wr_en)
                maxden_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        neg_reg   <= neg_next;
        p0_reg    <= p0_next;
        p1_reg    <= p1_next;
        q0_reg    <= q0_next;
        q1_reg    <= q1_next;
        tq_reg    <= tq_next;
        whole_reg <= whole_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
    end

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = ov_reg;
    assign out_ch.whole_part  = whole_reg;
    assign out_ch.numerator   = num_reg;
    assign out_ch.denominator = den_reg;

    // checks
    `CFRA_ASSERT_IMP(a_den_nonzero, out_ch.valid, out_ch.denominator != '0)
    `CFRA_ASSERT_NXT(a_busy_after_req, in_ch.valid && in_ch.ready, !in_ch.ready)
    `CFRA_ASSERT_IMP(a_one_unit, mac_stat.busy, !div_stat.busy)

endmodule

FILE: hdl/cfra_div.sv
// Restoring divider, one quotient bit per cycle, left-aligned dividend.
// Depends on cfra_pkg.
module cfra_div #(
    parameter int DIV_W = cfra_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfra_pkg::cfra_div_req_t      req,
    input  logic [cfra_pkg::DVD_W-1:0]   dividend,
    input  logic [DIV_W-1:0]             divisor,
    output cfra_pkg::cfra_stat_t         stat,
    output logic [cfra_pkg::QUO_W-1:0]   quotient,
    output logic [DIV_W-1:0]             remainder
);
    import cfra_pkg::*;

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W:0]   rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;
    logic             fits;

    // one restoring step
    assign trial = {rem_reg[DIV_W-1:0], dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (req.start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = req.nbits;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = fits ? (trial - {1'b0, divisor}) : trial;
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[DIV_W-1:0];

endmodule

FILE: hdl/cfra_mac.sv
// Shift-add multiply-accumulate: res = b * a + c (mod 2^64), a 16 bits.
// Depends on cfra_pkg.
module cfra_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cfra_pkg::VALUE_W-1:0]  b,
    input  logic [cfra_pkg::MAC_A_W-1:0]  a,
    input  logic [cfra_pkg::VALUE_W-1:0]  c,
    output cfra_pkg::cfra_stat_t          stat,
    output logic [cfra_pkg::VALUE_W-1:0]  res
);
    import cfra_pkg::*;

    localparam int MCNT_W = $clog2(MAC_A_W + 1);

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] b_reg, b_next;
    logic [MAC_A_W-1:0] a_reg, a_next;
    logic [MCNT_W-1:0]  cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    // one multiplier bit per cycle
    always_comb
    begin
        acc_next  = acc_reg;
        b_next    = b_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            acc_next  = c;
            b_next    = b;
            a_next    = a;
            cnt_next  = MCNT_W'(MAC_A_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (a_reg[0])
                acc_next = acc_reg + b_reg;
            b_next   = {b_reg[VALUE_W-2:0], 1'b0};
            a_next   = {1'b0, a_reg[MAC_A_W-1:1]};
            cnt_next = cnt_reg - MCNT_W'(1);
            if (cnt_reg == MCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        b_reg   <= b_next;
        a_reg   <= a_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res       = acc_reg;

endmodule

FILE: test/continued_fraction_rational_approx_unit_tb.sv
// Testbench for continued_fraction_rational_approx_unit: drives values with random
// spacing, predicts each mixed number in a scoreboard and checks every result.
// Depends on cfra_pkg, cfra_in_if, cfra_out_if and the unit itself.
module continued_fraction_rational_approx_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfra_pkg::*;

    localparam int FRAC   = FRAC_BITS_DEF;
    localparam int LIMIT  = 6000000;
    localparam int DRAIN  = 4000;
    localparam int HOLD   = 6000;

    typedef struct packed {
        logic [WHOLE_W-1:0] whole;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } mixed_t;

    // holds the denominator limit and the mixed numbers still to come
    class mixed_scoreboard;
        logic [DEN_W-1:0] max_den;
        mixed_t           pending_q[$];
        int               mismatches;
        int               checked;

        function new();
            max_den    = MAXDEN_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        // convergent recurrence on the magnitude, then split and sign
        function mixed_t approximate(logic [63:0] raw);
            bit          neg;
            bit [63:0]   x, ai, f, lim, p0, p1, q0, q1, t, ip, rm, whole, num;
            bit [127:0]  two64;
            mixed_t      res;
            neg   = raw[63];
            x     = neg ? 64'd0 - raw : raw;
            lim   = (max_den == 0) ? 64'd1 : {48'd0, max_den};
            p1    = 1; p0 = 0; q1 = 0; q0 = 1;
            two64 = 128'd1 << (2 * FRAC);
            while (1) begin
                ai = x >> FRAC;
                f  = x & ((64'd1 << FRAC) - 1);
                if (q1 != 0 && ai > lim) break;
                if (q1 * ai + q0 > lim) break;
                t  = p1 * ai + p0; p0 = p1; p1 = t;
                t  = q1 * ai + q0; q0 = q1; q1 = t;
                if (f == 0) break;
                ip = (64'd1 << FRAC) / f;
                rm = (64'd1 << FRAC) % f;
                // reciprocal too large to continue
                if (ip > 64'h7FFFFFFF || (ip == 64'h7FFFFFFF && rm != 0)) break;
                if ((ip >> (64 - FRAC)) != 0) break;
                x = 64'(two64 / {64'd0, f});
            end
            if (q1 == 0) q1 = 1;
            whole = p1 / q1;
            if (whole != 0) begin
                num = p1 - whole * q1;
                if (neg) begin
                    if (whole > 64'h80000000) whole = 64'h80000000;
                    res.whole = 32'(64'd0 - whole);
                end else begin
                    if (whole > 64'h7FFFFFFF) whole = 64'h7FFFFFFF;
                    res.whole = whole[31:0];
                end
                res.num = num[16:0];
            end else begin
                res.whole = '0;
                res.num   = neg ? 17'(64'd0 - p1) : p1[16:0];
            end
            res.den = q1[15:0];
            return res;
        endfunction

        function void note_request(logic [63:0] raw);
            pending_q.push_back(approximate(raw));
        endfunction

        function void check_result(mixed_t got);
            mixed_t exp_r;
            checked++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result w=%0d n=%0d d=%0d", $signed(got.whole),
                             $signed(got.num), got.den);
                return;
            end
            exp_r = pending_q.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: exp w=%0d n=%0d d=%0d, got w=%0d n=%0d d=%0d",
                             checked, $signed(exp_r.whole), $signed(exp_r.num), exp_r.den,
                             $signed(got.whole), $signed(got.num), got.den);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [DEN_W-1:0] cfg_wr_data;
    bit               quiet;
    bit               long_hold;
    int               cycles;
    int               sent;

    mixed_scoreboard sb;

    cfra_in_if  in_ch();
    cfra_out_if out_ch();

    continued_fraction_rational_approx_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch.sink),
        .out_ch      (out_ch.source)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle counter and timeout
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side: random stalls, plus the long hold-off when asked
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 8);
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                while (long_hold) @(posedge clk);
            end
            else if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            sb.check_result('{out_ch.whole_part, out_ch.numerator, out_ch.denominator});
        end
    end

    // one request, with a random gap ahead of it
    task automatic send_value(logic [63:0] v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.value_fixed <= v;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_request(v);
        sent++;
    endtask

    // drop valid and wait until every result is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
    endtask

    // limit register write, only while idle
    task automatic write_max_den(logic [DEN_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.max_den = v;
    endtask

    // random value of one of several shapes
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int unsigned a, b;
        case ($urandom_range(0, 4))
            0: v = {$urandom, $urandom};
            1: v = {28'd0, 4'($urandom), $urandom};
            2:
            begin
                a = $urandom_range(1, 3000);
                b = $urandom_range(1, 3000);
                v = ({32'd0, a} << FRAC) / b;
            end
            3: v = {48'd0, 16'($urandom)};
            default: v = {1'b0, 31'($urandom), $urandom};
        endcase
        if ($urandom_range(0, 1)) v = 64'd0 - v;
        return v;
    endfunction

    task automatic directed_set();
        logic [63:0] list[$];
        list = '{64'd0, 64'd1 << FRAC, 64'd0 - (64'd1 << FRAC), 64'h7FFFFFFF_FFFFFFFF,
                 64'h80000000_00000000, 64'h00000000_80000000, 64'hFFFFFFFF_80000000,
                 64'h00000003_243F6A89, 64'hFFFFFFFC_DBC09577, 64'd1, 64'hFFFFFFFF_FFFFFFFF,
                 64'h00000000_00000002, 64'h00000000_FFFFFFFF, 64'h00000000_55555555,
                 64'h00000002_B7E15163, 64'h7FFFFFFF_00000000, 64'h80000001_00000000,
                 64'h00000000_00010001};
        foreach (list[i]) send_value(list[i]);
    endtask

    initial
    begin
        logic [DEN_W-1:0] settings[6];
        sb          = new();
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.value_fixed = '0;
        quiet       = 1'b0;
        long_hold   = 1'b0;
        sent        = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed values under the reset limit, then under the extremes
        directed_set();
        write_max_den(16'd1);
        for (int i = 0; i < 4; i++) send_value(random_value());
        write_max_den(16'hFFFF);
        send_value(64'h00000003_243F6A89);
        send_value(64'hFFFFFFFF_FFFFFFFF);
        write_max_den(16'd0);
        send_value(64'h00000000_55555555);

        // random phases
        settings = '{16'd7, 16'hFFFF, 16'd1, 16'd0, 16'($urandom_range(2, 65534)), 16'd1000};
        foreach (settings[ph])
        begin
            write_max_den(settings[ph]);
            quiet = (ph == 4);
            if (ph == 2)
            begin
                fork
                    begin
                        long_hold = 1'b1;
                        repeat (HOLD) @(posedge clk);
                        long_hold = 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < 85; i++) send_value(random_value());
        end
        quiet = 1'b0;

        drain();
        repeat (DRAIN) @(posedge clk);
        $display("%0d values sent over limits 0, 1, 7, 1000, 65535 and one random limit",
                 sent);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
